// ----- hw/rtl/d2cm_pkg.sv -----
package d2cm_pkg;

	localparam int DEPTH_BITS_DEF = 16;
	localparam int LATENCY = 5;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FLOOR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RECIP = 2'd2;

	localparam logic MODE_GRAY = 1'b0;
	localparam logic MODE_COLOR = 1'b1;

	localparam logic [15:0] FLOOR_RST = 16'd0;
	localparam logic [31:0] RECIP_RST = 32'd65536;

	typedef logic [2:0][7:0] rgb_t;

	// seven-entry gradient, channel 2 is red, 1 green, 0 blue
	function automatic rgb_t grad_color(input logic [2:0] idx);
		rgb_t c;
		case (idx)
			3'd0: c = {8'h77, 8'h00, 8'h00};
			3'd1: c = {8'hFF, 8'h00, 8'h00};
			3'd2: c = {8'hF0, 8'hF0, 8'h00};
			3'd3: c = {8'h00, 8'hFF, 8'h00};
			3'd4: c = {8'h00, 8'h00, 8'hFF};
			3'd5: c = {8'h00, 8'h00, 8'h77};
			default: c = {8'h00, 8'h00, 8'h00};
		endcase
		return c;
	endfunction

endpackage

// ----- hw/rtl/depth_to_color_map.sv -----
// depth to color map: one depth sample in, one rgb pixel out
//
// input: an item is taken on each rising edge with start high; busy is
// always low, so a new sample may enter in every cycle
// output: red/green/blue are shown for exactly one cycle with done high,
// once the sample has passed the stages listed below; one pixel per sample, in
// order, at a sustained rate of one pixel per clock
// stages: subtract/compare, 32-bit reciprocal multiply, saturate and
// scale, gradient lookup with blend multiplies, final add and select
// configuration: cfg_valid/cfg_ready channel (ready always high) writing
// mode, depth floor or depth_reciprocal by cfg_index; other indexes are
// ignored; write only while no sample is in flight
// reset: arst_n clears the pipeline valid bits and loads mode gray,
// depth floor 0 and depth_reciprocal 65536; samples in flight are dropped
// the receiver cannot stall, so done is never held back
module depth_to_color_map
	import d2cm_pkg::*;
#(
	parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [DEPTH_BITS-1:0] depth,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]           cfg_data,
	output logic                  done,
	output logic [7:0]            red,
	output logic [7:0]            green,
	output logic [7:0]            blue
);

	localparam int DW = (DEPTH_BITS > 16) ? DEPTH_BITS : 16;
	localparam int PW = DW + 32;

	logic        mode_q;
	logic [15:0] floor_q;
	logic [31:0] recip_q;

	logic          valid_s1, mode_s1;
	logic [DW-1:0] diff_s1;
	logic          above_s1;

	logic          valid_s2, mode_s2, above_s2;
	logic [PW-1:0] prod_s2;

	logic        valid_s3, mode_s3, above_s3;
	logic [7:0]  gray_s3;
	logic [2:0]  idx_s3;
	logic [15:0] frac_s3;

	logic        valid_s4, mode_s4, above_s4;
	logic [7:0]  gray_s4;
	logic [2:0][24:0] wa_s4;
	logic [2:0][23:0] wb_s4;

	logic       done_q;
	rgb_t       pix_q;

	logic [DW-1:0] d_ext, lo_ext;
	logic          above_c;
	logic [15:0]   t_c;
	logic [23:0]   g24_c;
	logic [18:0]   pos_c;
	rgb_t          col_a, col_b;
	logic [16:0]   wlo_c;
	rgb_t          pix_c;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_GRAY;
			floor_q <= FLOOR_RST;
			recip_q <= RECIP_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MODE: mode_q <= cfg_data[0];
				CFG_FLOOR: floor_q <= cfg_data[15:0];
				CFG_RECIP: recip_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		d_ext = DW'(depth);
		lo_ext = DW'(floor_q);
		above_c = d_ext > lo_ext;
	end

	// saturate t to Q0.16, then gray = t*255>>16 and pos = t*6
	always_comb begin
		t_c = (|prod_s2[PW-1:32]) ? 16'hFFFF : prod_s2[31:16];
		if (!above_s2)
			t_c = 16'd0;
		g24_c = {t_c, 8'd0} - {8'd0, t_c};
		pos_c = {1'b0, t_c, 2'b00} + {2'b00, t_c, 1'b0};
	end

	always_comb begin
		col_a = grad_color(idx_s3);
		col_b = grad_color(idx_s3 + 3'd1);
		wlo_c = 17'h10000 - {1'b0, frac_s3};
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			pix_c[c] = 8'(({1'b0, wa_s4[c]} + {2'b00, wb_s4[c]}) >> 16);
		end
		if (mode_s4 == MODE_GRAY)
			pix_c = {gray_s4, gray_s4, gray_s4};
		else if (!above_s4)
			pix_c = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			done_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		mode_s1 <= mode_q;
		above_s1 <= above_c;
		diff_s1 <= above_c ? (d_ext - lo_ext) : '0;

		mode_s2 <= mode_s1;
		above_s2 <= above_s1;
		prod_s2 <= PW'(diff_s1) * PW'(recip_q);

		mode_s3 <= mode_s2;
		above_s3 <= above_s2;
		gray_s3 <= g24_c[23:16];
		idx_s3 <= pos_c[18:16];
		frac_s3 <= pos_c[15:0];

		mode_s4 <= mode_s3;
		above_s4 <= above_s3;
		gray_s4 <= gray_s3;
		for (int c = 0; c < 3; c++) begin
			wa_s4[c] <= col_a[c] * wlo_c;
			wb_s4[c] <= col_b[c] * frac_s3;
		end

		pix_q <= pix_c;
	end

	assign done = done_q;
	assign red = pix_q[2];
	assign green = pix_q[1];
	assign blue = pix_q[0];

endmodule

// ----- hw/rtl/d2cm_checker.sv -----
module d2cm_checker
	import d2cm_pkg::*;
#(
	parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  start,
	input logic                  busy,
	input logic [DEPTH_BITS-1:0] depth,
	input logic                  cfg_ready,
	input logic                  done,
	input logic [7:0]            red,
	input logic [7:0]            green,
	input logic [7:0]            blue
);

	// every accepted item comes out after the fixed latency
	a_item_out: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LATENCY done)
		else $error("accepted item gave no result");

	// no result without an accepted item
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##LATENCY !done)
		else $error("result without an item");

	// depth zero is never above the floor, so it maps to black in both modes
	a_zero_black: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && depth == '0 |->
			##LATENCY red == 8'd0 && green == 8'd0 && blue == 8'd0)
		else $error("zero depth not black");

	// block always takes items and config writes
	a_always_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && cfg_ready)
		else $error("block not ready");

endmodule

bind depth_to_color_map d2cm_checker #(.DEPTH_BITS(DEPTH_BITS)) u_d2cm_checker (.*);

// ----- test/depth_to_color_map_tb.sv -----
module depth_to_color_map_tb;
	import d2cm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	// gradient stops, red in the top byte
	localparam logic [0:6][23:0] RAMP = {
		24'h770000, 24'hFF0000, 24'hF0F000, 24'h00FF00,
		24'h0000FF, 24'h000077, 24'h000000
	};

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic [15:0] depth;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0] cfg_data;
	logic done;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	// shadow copy of the map registers
	logic map_mode;
	logic [15:0] map_min;
	logic [31:0] map_recip;

	pixel_t expected_pixels[$];
	int mismatches = 0;
	int gap_pct = 0;

	depth_to_color_map uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.depth(depth),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.red(red),
		.green(green),
		.blue(blue)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic pixel_t predict_pixel(input logic [15:0] d);
		logic [63:0] t;
		logic [63:0] pos;
		logic [63:0] frac;
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] v;
		logic [2:0] k;
		logic [23:0] lo_c;
		logic [23:0] hi_c;
		logic [2:0][7:0] ch;
		t = 64'd0;
		if (d > map_min) begin
			t = (({48'd0, d} - {48'd0, map_min}) * {32'd0, map_recip}) >> 16;
			if (t > 64'd65535)
				t = 64'd65535;
		end
		if (map_mode == MODE_GRAY) begin
			v = (t * 64'd255) >> 16;
			return '{v[7:0], v[7:0], v[7:0]};
		end
		if (d <= map_min)
			return '0;
		pos = t * 64'd6;
		frac = pos & 64'hFFFF;
		k = ((pos >> 16) > 64'd5) ? 3'd5 : pos[18:16];
		lo_c = RAMP[k];
		hi_c = RAMP[k + 3'd1];
		for (int c = 0; c < 3; c++) begin
			a = {56'd0, lo_c[8*c +: 8]};
			b = {56'd0, hi_c[8*c +: 8]};
			v = (a * (64'd65536 - frac) + b * frac) >> 16;
			ch[c] = v[7:0];
		end
		return pixel_t'(ch);
	endfunction

	// results are stable for the whole cycle, so look at them mid-cycle
	always @(negedge clk) begin
		pixel_t want;
		if (arst_n && done) begin
			if (expected_pixels.size() == 0) begin
				$error("pixel %0d/%0d/%0d with no item pending", red, green, blue);
				mismatches++;
			end else begin
				want = expected_pixels.pop_front();
				if (red !== want.red) begin
					$error("red: expected %0d, got %0d", want.red, red);
					mismatches++;
				end
				if (green !== want.green) begin
					$error("green: expected %0d, got %0d", want.green, green);
					mismatches++;
				end
				if (blue !== want.blue) begin
					$error("blue: expected %0d, got %0d", want.blue, blue);
					mismatches++;
				end
			end
		end
	end

	task automatic send_depth(input logic [15:0] d);
		logic ok;
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		depth <= d;
		forever begin
			@(negedge clk);
			ok = !busy;
			@(posedge clk);
			if (ok)
				break;
		end
		expected_pixels.push_back(predict_pixel(d));
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (expected_pixels.size() != 0)
			@(posedge clk);
	endtask

	// leaves cfg_valid high; the caller lowers it after the last write
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		logic ok;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		forever begin
			@(negedge clk);
			ok = cfg_ready;
			@(posedge clk);
			if (ok)
				break;
		end
		case (idx)
			CFG_MODE: map_mode = data[0];
			CFG_FLOOR: map_min = data[15:0];
			CFG_RECIP: map_recip = data;
			default: ;
		endcase
	endtask

	task automatic program_map(input logic m, input logic [15:0] lo, input logic [31:0] r);
		wait_drained();
		write_reg(CFG_MODE, {31'd0, m});
		write_reg(CFG_FLOOR, {16'd0, lo});
		write_reg(CFG_RECIP, r);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_reset_values();
		send_depth(16'd0);
		send_depth(16'd1);
		send_depth(16'd256);
		send_depth(16'h8000);
		send_depth(16'hFFFF);
	endtask

	task automatic test_gray_range();
		// huge reciprocal: anything above the floor saturates
		program_map(MODE_GRAY, 16'd1000, 32'hFFFF_FFFF);
		send_depth(16'd0);
		send_depth(16'd1000);
		send_depth(16'd1001);
		send_depth(16'hFFFF);
		program_map(MODE_GRAY, 16'd0, 32'd1);
		send_depth(16'hFFFF);
	endtask

	task automatic test_gradient_stops();
		program_map(MODE_COLOR, 16'd0, 32'd65536);
		send_depth(16'd0);
		send_depth(16'd1);
		send_depth(16'd10922);
		send_depth(16'd10923);
		send_depth(16'd21846);
		send_depth(16'd32768);
		send_depth(16'd43691);
		send_depth(16'd54614);
		send_depth(16'hFFFF);
		// depth equal to the floor is black
		program_map(MODE_COLOR, 16'hFFFF, 32'hFFFF_FFFF);
		send_depth(16'hFFFF);
	endtask

	task automatic test_zero_reciprocal();
		program_map(MODE_COLOR, 16'd100, 32'd0);
		send_depth(16'd100);
		send_depth(16'd101);
		send_depth(16'hFFFF);
		program_map(MODE_GRAY, 16'd100, 32'd0);
		send_depth(16'hFFFF);
	endtask

	task automatic test_register_fields();
		wait_drained();
		write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
		write_reg(CFG_MODE, 32'hFFFF_FFFE);
		write_reg(CFG_FLOOR, 32'hFFFF_0100);
		write_reg(CFG_RECIP, 32'h0003_0000);
		cfg_valid <= 1'b0;
		send_depth(16'h0100);
		send_depth(16'h0101);
		wait_drained();
		write_reg(CFG_MODE, 32'h0000_0003);
		write_reg(CFG_UNUSED, 32'h0);
		cfg_valid <= 1'b0;
		send_depth(16'h2345);
	endtask

	task automatic test_random_stream(input int pct, input int settings, input int per_setting);
		logic m;
		logic [15:0] lo;
		logic [31:0] r;
		logic [63:0] span;
		logic [63:0] d;
		gap_pct = pct;
		for (int s = 0; s < settings; s++) begin
			m = 1'($urandom_range(1));
			case ($urandom_range(5))
				0: lo = 16'd0;
				1: lo = 16'hFFFF;
				2: lo = 16'($urandom_range(1023));
				default: lo = 16'($urandom_range(65535));
			endcase
			span = 64'($urandom_range(65535, 1));
			case ($urandom_range(7))
				0: r = 32'd0;
				1: r = 32'd1;
				2: r = 32'hFFFF_FFFF;
				3: r = $urandom();
				default: begin
					d = 64'h1_0000_0000 / span;
					r = (d > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : d[31:0];
				end
			endcase
			program_map(m, lo, r);
			for (int i = 0; i < per_setting; i++) begin
				case ($urandom_range(9))
					0: d = 64'($urandom_range(65535));
					1: d = {48'd0, lo} + 64'($urandom_range(2));
					default: d = {48'd0, lo} + 64'($urandom_range(32'(span + span / 8)));
				endcase
				if (d > 64'hFFFF)
					d = 64'($urandom_range(65535));
				send_depth(d[15:0]);
			end
		end
		gap_pct = 0;
	endtask

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		depth <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_MODE;
		cfg_data <= '0;
		map_mode = MODE_GRAY;
		map_min = FLOOR_RST;
		map_recip = RECIP_RST;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_gray_range();
		test_gradient_stops();
		test_zero_reciprocal();
		test_register_fields();
		test_random_stream(0, 3, 120);
		test_random_stream(76, 3, 120);
		test_random_stream(15, 3, 120);

		wait_drained();
		repeat (LATENCY + 3) @(posedge clk);
		if (mismatches == 0 && expected_pixels.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#1ms;
		$display("FAILURE");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/d2cm_pkg.sv
hw/rtl/depth_to_color_map.sv
hw/rtl/d2cm_checker.sv
test/depth_to_color_map_tb.sv
